FILE: rtl/gtbr_pkg.sv
// ----------------------------------------------------------------------------
// gtbr_pkg
// Shared sizes, codes and the control bundle that the top level broadcasts
// to the row of column cells.
// ----------------------------------------------------------------------------
package gtbr_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int HEIGHT_W = 17;

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int LP_W   = $clog2(CELLS + 1);
   localparam int CNT_W  = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
   localparam int CFG_W  = 7;
   localparam int CSR_IDX_W = 1;

   // Request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 1'b1;

   // Control broadcast to every column cell
   typedef struct packed {
      logic             wr_h;      // write one height into a cell
      logic [ROW_W-1:0] wr_row;
      logic [COL_W-1:0] wr_col;
      logic [ROW_W-1:0] rd_row;    // row read from every cell this cycle
      logic             prime;     // latch first row of a pass into the window
      logic             step;      // update the middle row and shift the window
      logic [ROW_W-1:0] step_row;
      logic             pass0;     // replace stored reach bits by border seeds
      logic             up_vld;
      logic             dn_vld;
      logic [ROW_W-1:0] last_row;
      logic [COL_W-1:0] last_col;
   } gtbr_ctl_type;

endpackage

FILE: rtl/gtbr_cell.sv
// ----------------------------------------------------------------------------
// gtbr_cell
// One grid column: its heights and both reach bits per row, and a three-row
// window that relaxes the middle row against its four neighbors.
// ----------------------------------------------------------------------------
module gtbr_cell
   import gtbr_pkg::*;
(
   input  logic                clock,
   input  gtbr_ctl_type        ctl,
   input  logic [HEIGHT_W-1:0] wr_height,
   input  logic [COL_W-1:0]    col_idx,
   input  logic [HEIGHT_W-1:0] lft_h,
   input  logic                lft_a,
   input  logic                lft_b,
   input  logic [HEIGHT_W-1:0] rgt_h,
   input  logic                rgt_a,
   input  logic                rgt_b,
   output logic [HEIGHT_W-1:0] mid_h,
   output logic                mid_a,
   output logic                mid_b,
   output logic                both,
   output logic                changed
);

   logic [HEIGHT_W-1:0] h_mem [MAX_ROWS];
   logic                a_mem [MAX_ROWS];
   logic                b_mem [MAX_ROWS];

   logic [HEIGHT_W-1:0] h_rd_ff;
   logic                a_rd_ff, b_rd_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic [HEIGHT_W-1:0] mid_h_ff, up_h_ff;
   logic                mid_a_ff, mid_b_ff, up_a_ff, up_b_ff;

   logic active, lft_v, rgt_v;
   logic init_a, init_b, dn_a, dn_b;
   logic upd_a, upd_b;

   // Column in use and neighbor presence
   assign active = (col_idx <= ctl.last_col);
   assign lft_v  = (col_idx != '0);
   assign rgt_v  = (col_idx < ctl.last_col);

   // Seed the first pass from the borders
   assign init_a = (rd_row_ff == '0) || (col_idx == '0);
   assign init_b = (rd_row_ff == ctl.last_row) || (col_idx == ctl.last_col);
   assign dn_a   = ctl.pass0 ? init_a : a_rd_ff;
   assign dn_b   = ctl.pass0 ? init_b : b_rd_ff;

   // Spread into the middle cell from any reached neighbor not higher than it
   assign upd_a = mid_a_ff
      | (ctl.up_vld & up_a_ff & (mid_h_ff >= up_h_ff))
      | (ctl.dn_vld & dn_a    & (mid_h_ff >= h_rd_ff))
      | (lft_v      & lft_a   & (mid_h_ff >= lft_h))
      | (rgt_v      & rgt_a   & (mid_h_ff >= rgt_h));
   assign upd_b = mid_b_ff
      | (ctl.up_vld & up_b_ff & (mid_h_ff >= up_h_ff))
      | (ctl.dn_vld & dn_b    & (mid_h_ff >= h_rd_ff))
      | (lft_v      & lft_b   & (mid_h_ff >= lft_h))
      | (rgt_v      & rgt_b   & (mid_h_ff >= rgt_h));

   assign changed = active & ((upd_a & ~mid_a_ff) | (upd_b & ~mid_b_ff));
   assign both    = active & a_rd_ff & b_rd_ff;
   assign mid_h   = mid_h_ff;
   assign mid_a   = mid_a_ff;
   assign mid_b   = mid_b_ff;

   // Column storage: height writes, reach write-back, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_h && (ctl.wr_col == col_idx)) begin
         h_mem[ctl.wr_row] <= wr_height;
      end
      if (ctl.step) begin
         a_mem[ctl.step_row] <= upd_a;
         b_mem[ctl.step_row] <= upd_b;
      end
      h_rd_ff   <= h_mem[ctl.rd_row];
      a_rd_ff   <= a_mem[ctl.rd_row];
      b_rd_ff   <= b_mem[ctl.rd_row];
      rd_row_ff <= ctl.rd_row;
   end

   // Advance the row window
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         up_h_ff <= mid_h_ff;
         up_a_ff <= upd_a;
         up_b_ff <= upd_b;
      end
      if (ctl.step || ctl.prime) begin
         mid_h_ff <= h_rd_ff;
         mid_a_ff <= dn_a;
         mid_b_ff <= dn_b;
      end
   end

endmodule

FILE: rtl/grid_two_border_reachability_top.sv
// ----------------------------------------------------------------------------
// grid_two_border_reachability_top
// Loads a height grid, floods it from both border pairs with a row of column
// cells, and returns the cells that both floods reach, one per fetch.
// Load items: no result, busy stays low, one item per cycle.
// Fetch items: result strobed in the cycle after acceptance; busy may then stay
// high while the look-ahead search scans the remaining grid rows.
// Final load: busy while the heights are copied into the cells, then through
// sweep passes until a pass after the first changes nothing, then the row scan.
// Synchronous reset clears control state; height storage is not cleared.
// ----------------------------------------------------------------------------
module grid_two_border_reachability_top
   import gtbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [HEIGHT_W-1:0]  req_height,
   input  logic                 req_last_cell,
   output logic                 rsp_valid,
   output logic [ROW_W-1:0]     rsp_row,
   output logic [COL_W-1:0]     rsp_col,
   output logic                 rsp_found,
   output logic                 rsp_last_found,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_COPY      = 9'b000000010,
      ST_COPY_END  = 9'b000000100,
      ST_PRIME0    = 9'b000001000,
      ST_PRIME1    = 9'b000010000,
      ST_SWEEP     = 9'b000100000,
      ST_SCAN_RD   = 9'b001000000,
      ST_SCAN_VEC  = 9'b010000000,
      ST_SCAN_FIND = 9'b100000000
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int lim);
      logic [CNT_W-1:0] r;
      r = CNT_W'(v);
      if (v == '0) r = CNT_W'(1);
      else if (int'(v) > lim) r = CNT_W'(lim);
      return r;
   endfunction

   function automatic logic [COL_W-1:0] first_one(input logic [MAX_COLS-1:0] v);
      logic [COL_W-1:0] idx;
      idx = '0;
      for (int i = MAX_COLS - 1; i >= 0; i--) begin
         if (v[i]) idx = COL_W'(i);
      end
      return idx;
   endfunction

   state_type          state_ff;
   logic [CFG_W-1:0]   row_cnt_ff, col_cnt_ff;
   logic               res_phase_ff;
   logic [LP_W-1:0]    lp_ff;
   logic [CNT_W-1:0]   g_rows_ff, g_cols_ff;
   logic [HEIGHT_W-1:0] hmem [CELLS];
   logic [HEIGHT_W-1:0] hq_ff;
   logic [ROW_W-1:0]   cp_row_ff, cpw_row_ff;
   logic [COL_W-1:0]   cp_col_ff, cpw_col_ff;
   logic [CELL_W-1:0]  cp_idx_ff;
   logic               cpw_vld_ff;
   logic [ROW_W-1:0]   step_ff;
   logic               pass0_ff, chg_ff;
   logic [ROW_W-1:0]   srow_ff;
   logic [COL_W:0]     scol_ff;
   logic [MAX_COLS-1:0] vec_ff;
   logic               to_nxt_ff;
   logic               cur_vld_ff, nxt_vld_ff;
   logic [ROW_W-1:0]   cur_row_ff, nxt_row_ff;
   logic [COL_W-1:0]   cur_col_ff, nxt_col_ff;
   logic               rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;

   logic               accept;
   logic [CNT_W-1:0]   cl_rows, cl_cols;
   logic [2*CNT_W-1:0] total;
   logic [LP_W-1:0]    ld_ptr;
   logic [ROW_W-1:0]   last_row;
   logic [COL_W-1:0]   last_col;
   gtbr_ctl_type       ctl;
   logic [MAX_COLS-1:0] both_vec, chg_vec, col_mask;
   logic               chg_any;
   logic [COL_W-1:0]   hit_col;

   logic [HEIGHT_W-1:0] mid_h_w [MAX_COLS];
   logic [MAX_COLS-1:0] mid_a_w, mid_b_w;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign cl_rows  = clamp_size(row_cnt_ff, MAX_ROWS);
   assign cl_cols  = clamp_size(col_cnt_ff, MAX_COLS);
   assign total    = cl_rows * cl_cols;
   assign ld_ptr   = res_phase_ff ? '0 : lp_ff;
   assign last_row = ROW_W'(g_rows_ff - 1'b1);
   assign last_col = COL_W'(g_cols_ff - 1'b1);
   assign chg_any  = chg_ff | (|chg_vec);
   assign hit_col  = first_one(vec_ff);

   // Broadcast control to the column cells
   always_comb begin
      ctl          = '0;
      ctl.wr_h     = cpw_vld_ff;
      ctl.wr_row   = cpw_row_ff;
      ctl.wr_col   = cpw_col_ff;
      ctl.prime    = (state_ff == ST_PRIME1);
      ctl.step     = (state_ff == ST_SWEEP);
      ctl.step_row = step_ff;
      ctl.pass0    = pass0_ff;
      ctl.up_vld   = (step_ff != '0);
      ctl.dn_vld   = (step_ff != last_row);
      ctl.last_row = last_row;
      ctl.last_col = last_col;
      unique case (state_ff)
         ST_PRIME1:  ctl.rd_row = ROW_W'(1);
         ST_SWEEP:   ctl.rd_row = ROW_W'(step_ff + 2'd2);
         ST_SCAN_RD: ctl.rd_row = srow_ff;
         default:    ctl.rd_row = '0;
      endcase
   end

   // Row of column cells, each wired to its left and right neighbor
   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic [HEIGHT_W-1:0] lh, rh;
      logic                la, lb, ra, rb;
      if (c > 0) begin : g_l
         assign lh = mid_h_w[c-1];
         assign la = mid_a_w[c-1];
         assign lb = mid_b_w[c-1];
      end else begin : g_l0
         assign lh = '0;
         assign la = 1'b0;
         assign lb = 1'b0;
      end
      if (c < MAX_COLS - 1) begin : g_r
         assign rh = mid_h_w[c+1];
         assign ra = mid_a_w[c+1];
         assign rb = mid_b_w[c+1];
      end else begin : g_r0
         assign rh = '0;
         assign ra = 1'b0;
         assign rb = 1'b0;
      end
      gtbr_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wr_height (hq_ff),
         .col_idx   (COL_W'(c)),
         .lft_h     (lh),
         .lft_a     (la),
         .lft_b     (lb),
         .rgt_h     (rh),
         .rgt_a     (ra),
         .rgt_b     (rb),
         .mid_h     (mid_h_w[c]),
         .mid_a     (mid_a_w[c]),
         .mid_b     (mid_b_w[c]),
         .both      (both_vec[c]),
         .changed   (chg_vec[c])
      );
      assign col_mask[c] = ((COL_W+1)'(c) >= scol_ff);
   end

   // Linear height store: load writes, copy reads
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_LOAD) && ((2*CNT_W)'(ld_ptr) < total)) begin
         hmem[ld_ptr[CELL_W-1:0]] <= req_height;
      end
      hq_ff <= hmem[cp_idx_ff];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= CFG_W'(64);
         col_cnt_ff <= CFG_W'(64);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW_COUNT: row_cnt_ff <= csr_wdata;
            REG_COL_COUNT: col_cnt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: load, copy, sweep passes, result scans, fetch answers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_phase_ff <= 1'b0;
         lp_ff        <= '0;
         g_rows_ff    <= CNT_W'(MAX_ROWS);
         g_cols_ff    <= CNT_W'(MAX_COLS);
         cpw_vld_ff   <= 1'b0;
         pass0_ff     <= 1'b0;
         chg_ff       <= 1'b0;
         cur_vld_ff   <= 1'b0;
         nxt_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept && (req_opcode == OP_FETCH);
         cpw_vld_ff   <= (state_ff == ST_COPY);
         cpw_row_ff   <= cp_row_ff;
         cpw_col_ff   <= cp_col_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_opcode == OP_LOAD)) begin
                  if (req_last_cell) begin
                     g_rows_ff    <= cl_rows;
                     g_cols_ff    <= cl_cols;
                     lp_ff        <= '0;
                     res_phase_ff <= 1'b1;
                     cur_vld_ff   <= 1'b0;
                     nxt_vld_ff   <= 1'b0;
                     cp_row_ff    <= '0;
                     cp_col_ff    <= '0;
                     cp_idx_ff    <= '0;
                     state_ff     <= ST_COPY;
                  end else begin
                     res_phase_ff <= 1'b0;
                     if ((2*CNT_W)'(ld_ptr) < total) lp_ff <= LP_W'(ld_ptr + 1'b1);
                     else lp_ff <= ld_ptr;
                  end
               end else if (accept) begin
                  if (res_phase_ff && cur_vld_ff) begin
                     rsp_found_ff <= 1'b1;
                     rsp_last_ff  <= ~nxt_vld_ff;
                     rsp_row_ff   <= cur_row_ff;
                     rsp_col_ff   <= cur_col_ff;
                     if (nxt_vld_ff) begin
                        cur_row_ff <= nxt_row_ff;
                        cur_col_ff <= nxt_col_ff;
                        srow_ff    <= nxt_row_ff;
                        scol_ff    <= (COL_W+1)'(nxt_col_ff) + 1'b1;
                        to_nxt_ff  <= 1'b1;
                        state_ff   <= ST_SCAN_RD;
                     end else begin
                        cur_vld_ff <= 1'b0;
                     end
                  end else begin
                     rsp_found_ff <= 1'b0;
                     rsp_last_ff  <= 1'b0;
                     rsp_row_ff   <= '0;
                     rsp_col_ff   <= '0;
                  end
               end
            end
            ST_COPY: begin
               cp_idx_ff <= CELL_W'(cp_idx_ff + 1'b1);
               if (cp_col_ff == last_col) begin
                  cp_col_ff <= '0;
                  cp_row_ff <= ROW_W'(cp_row_ff + 1'b1);
                  if (cp_row_ff == last_row) state_ff <= ST_COPY_END;
               end else begin
                  cp_col_ff <= COL_W'(cp_col_ff + 1'b1);
               end
            end
            ST_COPY_END: begin
               pass0_ff <= 1'b1;
               chg_ff   <= 1'b0;
               state_ff <= ST_PRIME0;
            end
            ST_PRIME0: state_ff <= ST_PRIME1;
            ST_PRIME1: begin
               step_ff  <= '0;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (step_ff == last_row) begin
                  chg_ff <= 1'b0;
                  if (pass0_ff || chg_any) begin
                     pass0_ff <= 1'b0;
                     state_ff <= ST_PRIME0;
                  end else begin
                     srow_ff   <= '0;
                     scol_ff   <= '0;
                     to_nxt_ff <= 1'b0;
                     state_ff  <= ST_SCAN_RD;
                  end
               end else begin
                  step_ff <= ROW_W'(step_ff + 1'b1);
                  chg_ff  <= chg_any;
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_VEC;
            ST_SCAN_VEC: begin
               vec_ff   <= both_vec & col_mask;
               state_ff <= ST_SCAN_FIND;
            end
            ST_SCAN_FIND: begin
               if (vec_ff != '0) begin
                  if (to_nxt_ff) begin
                     nxt_vld_ff <= 1'b1;
                     nxt_row_ff <= srow_ff;
                     nxt_col_ff <= hit_col;
                     state_ff   <= ST_IDLE;
                  end else begin
                     cur_vld_ff <= 1'b1;
                     cur_row_ff <= srow_ff;
                     cur_col_ff <= hit_col;
                     scol_ff    <= (COL_W+1)'(hit_col) + 1'b1;
                     to_nxt_ff  <= 1'b1;
                     state_ff   <= ST_SCAN_RD;
                  end
               end else if (srow_ff == last_row) begin
                  nxt_vld_ff <= 1'b0;
                  if (!to_nxt_ff) cur_vld_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  srow_ff  <= ROW_W'(srow_ff + 1'b1);
                  scol_ff  <= '0;
                  state_ff <= ST_SCAN_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_valid_ff & rsp_found_ff;
   assign rsp_last_found = rsp_valid_ff & rsp_last_ff;
   assign rsp_row        = rsp_valid_ff ? rsp_row_ff : '0;
   assign rsp_col        = rsp_valid_ff ? rsp_col_ff : '0;

   // A result only ever follows an accepted fetch
   a_rsp_after_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (req_opcode == OP_FETCH)))
      else $error("result without a fetch");

   // A look-ahead cell is only held behind a current cell
   a_nxt_behind_cur: assert property (@(posedge clock) disable iff (reset)
      (nxt_vld_ff && (state_ff == ST_IDLE)) |-> cur_vld_ff)
      else $error("look-ahead cell without current cell");

   // Returned cells lie inside the latched grid
   a_found_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> ((rsp_row <= last_row) && (rsp_col <= last_col)))
      else $error("returned cell outside grid");

   // Last mark only on a found cell
   a_last_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_last_found |-> rsp_found)
      else $error("last mark without a found cell");

endmodule
